// ===== src/assert_macros.svh =====
// Assertion macros for the RTL files; turtle_vector_stepper includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define TVS_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define TVS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tvs_pkg.sv =====
package tvs_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int STEPS_W        = 16;
  localparam int ANGLE_W        = 16;
  localparam int HEAD_W         = 9;
  localparam int CENTER_W       = 15;
  localparam int COLOR_W        = 32;
  localparam int BLEND_W        = 2;
  localparam int CMD_W          = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int QUARTER        = 90;
  localparam int SIN_IDX_W      = $clog2(QUARTER + 1);
  localparam int WRAP_ENTRIES   = 256;
  localparam int WRAP_IDX_W     = $clog2(WRAP_ENTRIES);

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic signed [COORD_WIDTH-1:0]  coord_t;
  typedef logic signed [STEPS_W-1:0]      steps_t;
  typedef logic signed [ANGLE_W-1:0]      angle_t;
  typedef logic [HEAD_W-1:0]              heading_t;
  typedef logic [CENTER_W-1:0]            center_t;
  typedef logic [COLOR_W-1:0]             color_t;
  typedef logic [BLEND_W-1:0]             blend_t;
  typedef logic [CMD_W-1:0]               cmd_t;
  typedef logic [CFG_IDX_W-1:0]           cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]          cfg_data_t;
  typedef logic [TRIG_FRAC_BITS:0]        trig_mag_t;
  typedef logic signed [TRIG_FRAC_BITS+1:0] trig_t;
  typedef trig_mag_t [QUARTER:0]          sin_rom_t;
  typedef heading_t [WRAP_ENTRIES-1:0]    wrap_rom_t;

  localparam heading_t DEG_90  = HEAD_W'(90);
  localparam heading_t DEG_180 = HEAD_W'(180);
  localparam heading_t DEG_270 = HEAD_W'(270);
  localparam heading_t DEG_360 = HEAD_W'(360);

  typedef enum logic [CMD_W-1:0] {
    CMD_MOVE        = 3'd0,
    CMD_ROTATE      = 3'd1,
    CMD_SET_HEADING = 3'd2,
    CMD_SET_POS     = 3'd3,
    CMD_HOME        = 3'd4,
    CMD_SET_PEN     = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_UP_HEADING = 3'd2,
    REG_PEN_COLOR  = 3'd3,
    REG_BLEND_MODE = 3'd4
  } cfg_reg_e;

  localparam center_t  CENTER_X_RST   = CENTER_W'(320);
  localparam center_t  CENTER_Y_RST   = CENTER_W'(240);
  localparam heading_t UP_HEADING_RST = HEAD_W'(270);
  localparam color_t   PEN_COLOR_RST  = '1;
  localparam blend_t   BLEND_MODE_RST = '0;

  typedef struct packed {
    center_t  center_x;
    center_t  center_y;
    heading_t up_heading;
    color_t   pen_color;
    blend_t   blend_mode;
  } cfg_t;

  typedef struct packed {
    cmd_t   cmd;
    steps_t steps;
    angle_t angle;
    coord_t new_x;
    coord_t new_y;
    logic   pen_down;
  } item_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   own_color;
    color_t line_color;
    blend_t line_blend;
  } line_t;

  typedef struct packed {
    logic  emit;
    line_t line;
  } exec_res_t;

  // Quarter-wave sine table, built from a Taylor series in Q30.
  function automatic sin_rom_t build_sin_rom();
    sin_rom_t          rom;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] sum;
    int                sh;
    sh = 30 - TRIG_FRAC_BITS;
    for (int d = 0; d <= QUARTER; d++) begin
      x = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
      x2 = (x * x) >> 30;
      term = x;
      sum = signed'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      rom[d] = trig_mag_t'((unsigned'(sum) + (64'd1 << (sh - 1))) >> sh);
    end
    return rom;
  endfunction

  // Residue modulo 360 of the angle's upper byte weighted by 256.
  function automatic wrap_rom_t build_wrap_rom();
    wrap_rom_t rom;
    int        hi;
    int        m;
    for (int h = 0; h < WRAP_ENTRIES; h++) begin
      hi = (h < WRAP_ENTRIES / 2) ? h : h - WRAP_ENTRIES;
      m = (hi * WRAP_ENTRIES) % 360;
      if (m < 0) begin
        m = m + 360;
      end
      rom[h] = HEAD_W'(m);
    end
    return rom;
  endfunction

  localparam sin_rom_t  SIN_ROM  = build_sin_rom();
  localparam wrap_rom_t WRAP_ROM = build_wrap_rom();

  function automatic heading_t reduce_heading(logic [HEAD_W:0] v);
    logic [HEAD_W:0] r;
    r = v;
    if (r >= {1'b0, DEG_360}) begin
      r = r - {1'b0, DEG_360};
    end
    return HEAD_W'(r);
  endfunction

  function automatic heading_t wrap_angle(angle_t a);
    logic [HEAD_W:0] s;
    s = {1'b0, WRAP_ROM[a[ANGLE_W-1 -: WRAP_IDX_W]]}
        + (HEAD_W + 1)'(a[ANGLE_W-WRAP_IDX_W-1:0]);
    return reduce_heading(s);
  endfunction

  function automatic heading_t add_heading(heading_t h, heading_t d);
    return reduce_heading({1'b0, h} + {1'b0, d});
  endfunction

  function automatic trig_t sin_deg(heading_t h);
    heading_t  idx;
    logic      neg;
    trig_t     v;
    if (h < DEG_90) begin
      idx = h;
      neg = 1'b0;
    end else if (h < DEG_180) begin
      idx = DEG_180 - h;
      neg = 1'b0;
    end else if (h < DEG_270) begin
      idx = h - DEG_180;
      neg = 1'b1;
    end else begin
      idx = DEG_360 - h;
      neg = 1'b1;
    end
    v = {1'b0, SIN_ROM[idx[SIN_IDX_W-1:0]]};
    if (neg) begin
      v = -v;
    end
    return v;
  endfunction

  function automatic coord_t home_coord(center_t c);
    logic [CFG_DATA_W:0] wide;
    logic [CFG_DATA_W:0] cmax;
    wide = (CFG_DATA_W + 1)'(c);
    cmax = ((CFG_DATA_W + 1)'(1) << (COORD_WIDTH - 1)) - 1'b1;
    if (wide > cmax) begin
      wide = cmax;
    end
    return COORD_WIDTH'(wide);
  endfunction

endpackage

// ===== src/tvs_in_if.sv =====
interface tvs_in_if;
  logic             valid;
  logic             ready;
  tvs_pkg::cmd_t    cmd;
  tvs_pkg::steps_t  steps;
  tvs_pkg::angle_t  angle;
  tvs_pkg::coord_t  new_x;
  tvs_pkg::coord_t  new_y;
  logic             pen_down;

  modport source (output valid, cmd, steps, angle, new_x, new_y, pen_down, input ready);
  modport sink (input valid, cmd, steps, angle, new_x, new_y, pen_down, output ready);
endinterface

// ===== src/tvs_out_if.sv =====
interface tvs_out_if;
  logic             valid;
  logic             ready;
  tvs_pkg::coord_t  start_x;
  tvs_pkg::coord_t  start_y;
  tvs_pkg::coord_t  end_x;
  tvs_pkg::coord_t  end_y;
  logic             own_color;
  tvs_pkg::color_t  line_color;
  tvs_pkg::blend_t  line_blend;

  modport source (output valid, start_x, start_y, end_x, end_y, own_color, line_color,
                  line_blend, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, own_color, line_color,
                line_blend, output ready);
endinterface

// ===== src/tvs_cfg_if.sv =====
interface tvs_cfg_if;
  logic                valid;
  logic                ready;
  tvs_pkg::cfg_idx_t   index;
  tvs_pkg::cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/tvs_cfg_regs.sv =====
module tvs_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  tvs_cfg_if.sink        cfg_bus,
  output tvs_pkg::cfg_t  cfg
);
  import tvs_pkg::*;

  cfg_t cfg_r;

  assign cfg_bus.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x   <= CENTER_X_RST;
      cfg_r.center_y   <= CENTER_Y_RST;
      cfg_r.up_heading <= UP_HEADING_RST;
      cfg_r.pen_color  <= PEN_COLOR_RST;
      cfg_r.blend_mode <= BLEND_MODE_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_CENTER_X:   cfg_r.center_x   <= cfg_bus.data[CENTER_W-1:0];
        REG_CENTER_Y:   cfg_r.center_y   <= cfg_bus.data[CENTER_W-1:0];
        REG_UP_HEADING: cfg_r.up_heading <= cfg_bus.data[HEAD_W-1:0];
        REG_PEN_COLOR:  cfg_r.pen_color  <= cfg_bus.data[COLOR_W-1:0];
        REG_BLEND_MODE: cfg_r.blend_mode <= cfg_bus.data[BLEND_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== src/tvs_axis_step.sv =====
module tvs_axis_step (
  input  tvs_pkg::coord_t  pos,
  input  tvs_pkg::steps_t  steps,
  input  tvs_pkg::trig_t   trig,
  output tvs_pkg::coord_t  coord
);
  import tvs_pkg::*;

  localparam int BASE_W = (COORD_WIDTH > STEPS_W + 1) ? COORD_WIDTH : STEPS_W + 1;
  localparam int SUM_W  = BASE_W + TRIG_FRAC_BITS + 2;
  localparam int PROD_W = STEPS_W + TRIG_FRAC_BITS + 2;

  localparam logic signed [SUM_W-1:0] HALF      = SUM_W'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] COORD_MAX = (SUM_W'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam logic signed [SUM_W-1:0] COORD_MIN = -(SUM_W'(1) <<< (COORD_WIDTH - 1));

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  rounded;
  logic signed [SUM_W-1:0]  clipped;

  assign prod = PROD_W'(steps) * PROD_W'(trig);
  assign acc = (SUM_W'(pos) <<< TRIG_FRAC_BITS) + SUM_W'(prod) + HALF;
  assign rounded = acc >>> TRIG_FRAC_BITS;

  always_comb begin
    if (rounded > COORD_MAX) begin
      clipped = COORD_MAX;
    end else if (rounded < COORD_MIN) begin
      clipped = COORD_MIN;
    end else begin
      clipped = rounded;
    end
  end

  assign coord = clipped[COORD_WIDTH-1:0];
endmodule

// ===== src/tvs_exec.sv =====
module tvs_exec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  tvs_pkg::item_t      item,
  input  tvs_pkg::cfg_t       cfg,
  output tvs_pkg::exec_res_t  res
);
  import tvs_pkg::*;

  coord_t   pos_x_r;
  coord_t   pos_y_r;
  heading_t heading_r;
  logic     pen_r;
  coord_t   pos_x_nxt;
  coord_t   pos_y_nxt;
  heading_t heading_nxt;
  logic     pen_nxt;
  trig_t    cos_v;
  trig_t    sin_v;
  coord_t   move_x;
  coord_t   move_y;

  assign sin_v = sin_deg(heading_r);
  assign cos_v = sin_deg(reduce_heading({1'b0, heading_r} + {1'b0, DEG_90}));

  tvs_axis_step u_step_x (
    .pos   (pos_x_r),
    .steps (item.steps),
    .trig  (cos_v),
    .coord (move_x)
  );

  tvs_axis_step u_step_y (
    .pos   (pos_y_r),
    .steps (item.steps),
    .trig  (sin_v),
    .coord (move_y)
  );

  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    heading_nxt = heading_r;
    pen_nxt     = pen_r;
    res         = '0;
    case (item.cmd)
      CMD_MOVE: begin
        pos_x_nxt           = move_x;
        pos_y_nxt           = move_y;
        res.emit            = pen_r;
        res.line.own_color  = 1'b1;
        res.line.line_color = cfg.pen_color;
        res.line.line_blend = cfg.blend_mode;
      end
      CMD_ROTATE: begin
        heading_nxt = add_heading(heading_r, wrap_angle(item.angle));
      end
      CMD_SET_HEADING: begin
        heading_nxt = wrap_angle(item.angle);
      end
      CMD_SET_POS: begin
        pos_x_nxt = item.new_x;
        pos_y_nxt = item.new_y;
        res.emit  = pen_r;
      end
      CMD_HOME: begin
        pos_x_nxt   = home_coord(cfg.center_x);
        pos_y_nxt   = home_coord(cfg.center_y);
        heading_nxt = reduce_heading({1'b0, cfg.up_heading});
        pen_nxt     = 1'b1;
      end
      CMD_SET_PEN: begin
        pen_nxt = item.pen_down;
      end
      default: ;
    endcase
    res.line.start_x = pos_x_r;
    res.line.start_y = pos_y_r;
    res.line.end_x   = pos_x_nxt;
    res.line.end_y   = pos_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= home_coord(CENTER_X_RST);
      pos_y_r   <= home_coord(CENTER_Y_RST);
      heading_r <= reduce_heading({1'b0, UP_HEADING_RST});
      pen_r     <= 1'b1;
    end else if (fire) begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      heading_r <= heading_nxt;
      pen_r     <= pen_nxt;
    end
  end
endmodule

// ===== src/turtle_vector_stepper.sv =====
// Channel   Direction  Beat contents
// in_bus    sink       cmd, steps, angle, new_x, new_y, pen_down
// out_bus   source     start_x, start_y, end_x, end_y, own_color, line_color, line_blend
// cfg_bus   sink       index, data (always ready)
//
// An accepted beat sits in the input register until it executes, when the turtle
// state is updated; a line segment that it draws is registered then for out_bus.
// One beat per cycle is sustained while out_bus takes segments; the table lookup, the
// two multiplies and the rounding add between the input and state/result registers set that.
// A stalled output register holds back only commands that draw a line.
// Reset is synchronous and needs no clearing pass.
module turtle_vector_stepper (
  input  logic       clk,
  input  logic       rst_n,
  tvs_in_if.sink     in_bus,
  tvs_out_if.source  out_bus,
  tvs_cfg_if.sink    cfg_bus
);
  import tvs_pkg::*;

  `include "assert_macros.svh"

  cfg_t      cfg;
  item_t     item_r;
  logic      item_valid_r;
  line_t     out_line_r;
  logic      out_valid_r;
  exec_res_t res;
  logic      out_free;
  logic      exec_go;

  tvs_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  tvs_exec u_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (exec_go),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_free     = !out_valid_r || out_bus.ready;
  assign exec_go      = item_valid_r && (!res.emit || out_free);
  assign in_bus.ready = !item_valid_r || exec_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      item_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r.cmd      <= in_bus.cmd;
      item_r.steps    <= in_bus.steps;
      item_r.angle    <= in_bus.angle;
      item_r.new_x    <= in_bus.new_x;
      item_r.new_y    <= in_bus.new_y;
      item_r.pen_down <= in_bus.pen_down;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && res.emit) begin
      out_line_r <= res.line;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.start_x    = out_line_r.start_x;
  assign out_bus.start_y    = out_line_r.start_y;
  assign out_bus.end_x      = out_line_r.end_x;
  assign out_bus.end_y      = out_line_r.end_y;
  assign out_bus.own_color  = out_line_r.own_color;
  assign out_bus.line_color = out_line_r.line_color;
  assign out_bus.line_blend = out_line_r.line_blend;

  `TVS_ASSERT_NEXT(a_emit_loads_output, exec_go && res.emit, out_valid_r, "segment was not registered")
  `TVS_ASSERT_NEXT(a_accept_fills_input, in_bus.valid && in_bus.ready, item_valid_r, "accepted beat was dropped")
  `TVS_ASSERT(a_plain_line_no_color, !out_valid_r || out_line_r.own_color || (out_line_r.line_color == '0 && out_line_r.line_blend == '0), "set-position line carries a color")
endmodule
